// File: design/mm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mm_pkg;
    localparam int MAX_DIM_DEF = 8;
    localparam int DIM_W = 4;
    localparam int IDX_W = 3;
    localparam int VAL_W = 32;
    localparam int ACC_W = 72;

    typedef enum logic [1:0] {
        ACT_WRITE_A = 2'd0,
        ACT_WRITE_B = 2'd1,
        ACT_MULTIPLY = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        REG_ROWS_A = 2'd0,
        REG_INNER = 2'd1,
        REG_COLS_B = 2'd2
    } t_reg;

    // control handed from the sequencer into the cell row
    typedef struct packed {
        logic clear;
        logic feed;
    } t_cell_ctl;

    function automatic logic [VAL_W-1:0] sat_q16(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] t;
        t = s >>> 16;
        if (t > ACC_W'(signed'(33'sh0_7FFF_FFFF))) return 32'h7FFF_FFFF;
        if (t < -ACC_W'(signed'(34'sh0_8000_0000))) return 32'h8000_0000;
        return t[VAL_W-1:0];
    endfunction
endpackage
`default_nettype wire

// File: design/mm_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [2:0]  row_index;
    logic [2:0]  col_index;
    logic signed [31:0] element_value;
    modport source (output valid, action, row_index, col_index, element_value,
                    input ready);
    modport sink (input valid, action, row_index, col_index, element_value,
                  output ready);
endinterface

interface mm_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [2:0]  out_row;
    logic [2:0]  out_col;
    logic signed [31:0] out_value;
    logic        last;
    modport source (output valid, status, out_row, out_col, out_value, last,
                    input ready);
    modport sink (input valid, status, out_row, out_col, out_value, last,
                  output ready);
endinterface
`default_nettype wire

// File: design/matrix_multiplier.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Payload
// s_in      in   action, row_index, col_index, element_value
// m_out     out  status, out_row, out_col, out_value, last
// cfg       in   i_cfg_we, i_cfg_index, i_cfg_data (rows_a, inner_dim, cols_b)
// A write beat is taken one per cycle while the sequencer is idle and the output
// register is free or being drained. A multiply walks C one row at a time
// through a row of MAX_DIM cells: row k of B shifts in one word per cycle, so a
// row of C is fed for every k, then drained, then sent as cols_b emit beats.
// Synchronous active-low reset clears control and sets the dimensions to 1; the
// stores are not cleared. Output stalls hold.
module matrix_multiplier
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [DIM_W-1:0] i_cfg_data,
    mm_in_if.sink            s_in,
    mm_out_if.source         m_out
);
    localparam int AW = $clog2(MAX_DIM);
    localparam int DEPTH = 2 ** (2 * AW);

    logic [DIM_W-1:0] r_rows, r_inner, r_cols;
    logic [VAL_W-1:0] mem_a [DEPTH];
    logic [VAL_W-1:0] mem_b [DEPTH];

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_r, r_k, r_c, r_j;
    logic [1:0] r_dr;
    logic [VAL_W-1:0] r_aval;
    logic [VAL_W-1:0] r_bval;
    logic signed [ACC_W-1:0] acc [MAX_DIM];
    logic [VAL_W-1:0] b_chain [MAX_DIM+1];
    t_cell_ctl ctl;
    logic r_feed;

    logic r_ov, r_st, r_last;
    logic [IDX_W-1:0] r_or, r_oc;
    logic [VAL_W-1:0] r_oval;
    logic out_free, acc_in, is_wr, bad;

    function automatic logic [DIM_W-1:0] clampd(input logic [DIM_W-1:0] v);
        if (v == '0) return DIM_W'(1);
        if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
        return v;
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= DIM_W'(1); r_inner <= DIM_W'(1); r_cols <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_index))
                REG_ROWS_A: r_rows <= clampd(i_cfg_data);
                REG_INNER:  r_inner <= clampd(i_cfg_data);
                REG_COLS_B: r_cols <= clampd(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign out_free = !r_ov || m_out.ready;
    assign s_in.ready = (r_state == ST_IDLE) && out_free;
    assign acc_in = s_in.valid && s_in.ready;
    assign is_wr = (s_in.action == ACT_WRITE_A) || (s_in.action == ACT_WRITE_B);
    always_comb begin
        if (s_in.action == ACT_WRITE_A)
            bad = ({1'b0, s_in.row_index} >= r_rows) ||
                  ({1'b0, s_in.col_index} >= r_inner);
        else
            bad = ({1'b0, s_in.row_index} >= r_inner) ||
                  ({1'b0, s_in.col_index} >= r_cols);
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (acc_in && !bad && s_in.action == ACT_WRITE_A)
            mem_a[{s_in.row_index[AW-1:0], s_in.col_index[AW-1:0]}] <= s_in.element_value;
        if (acc_in && !bad && s_in.action == ACT_WRITE_B)
            mem_b[{s_in.row_index[AW-1:0], s_in.col_index[AW-1:0]}] <= s_in.element_value;
    end

    // store reads for the cell row: A(r,k), and B(k,j) from the last column down
    always_ff @(posedge i_clk) begin
        r_aval <= mem_a[{r_r[AW-1:0], r_k[AW-1:0]}];
        r_bval <= mem_b[{r_k[AW-1:0], r_j[AW-1:0]}];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (acc_in && s_in.action == ACT_MULTIPLY) n_state = ST_FEED;
            ST_FEED:  if ({1'b0, r_k} == r_inner - 1'b1 && r_j == '0) n_state = ST_DRAIN;
            ST_DRAIN: if (r_dr == 2'd2) n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free && {1'b0, r_c} == r_cols - 1'b1)
                    n_state = ({1'b0, r_r} == r_rows - 1'b1) ? ST_IDLE : ST_FEED;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_r <= '0; r_k <= '0; r_c <= '0; r_j <= '0; r_dr <= '0; r_feed <= 1'b0;
        end else begin
            r_state <= n_state;
            // strobe when B(k,0) is read: the whole B row then lines up in the cells
            r_feed <= (r_state == ST_FEED) && (r_j == '0);
            case (r_state)
                ST_IDLE: begin
                    r_r <= '0; r_k <= '0; r_c <= '0; r_dr <= '0;
                    r_j <= IDX_W'(r_cols - 1'b1);
                end
                ST_FEED: begin
                    r_dr <= '0;
                    if (r_j == '0) begin
                        r_j <= IDX_W'(r_cols - 1'b1);
                        r_k <= r_k + 1'b1;
                    end else r_j <= r_j - 1'b1;
                end
                ST_DRAIN: r_dr <= r_dr + 1'b1;
                ST_EMIT: if (out_free) begin
                    r_k <= '0;
                    r_j <= IDX_W'(r_cols - 1'b1);
                    if ({1'b0, r_c} == r_cols - 1'b1) begin
                        r_c <= '0; r_r <= r_r + 1'b1;
                    end else r_c <= r_c + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // cell controls; sums clear while idle and on the last emit beat of a row
    always_comb begin
        ctl.clear = (r_state == ST_IDLE) ||
                    ((r_state == ST_EMIT) && out_free && ({1'b0, r_c} == r_cols - 1'b1));
        ctl.feed = r_feed;
    end

    // cell row; B words shift along the chain, A is seen by all cells
    assign b_chain[0] = r_bval;
    for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
        mm_cell u_cell (
            .i_clk (i_clk), .i_ctl (ctl),
            .i_a (r_aval), .i_b (b_chain[g]),
            .o_b (b_chain[g+1]), .o_acc (acc[g])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= 1'b0;
            if (acc_in && is_wr) begin
                r_ov <= 1'b1; r_st <= bad; r_or <= '0; r_oc <= '0;
                r_oval <= '0; r_last <= 1'b1;
            end else if (r_state == ST_EMIT) begin
                r_ov <= 1'b1; r_st <= 1'b0; r_or <= r_r; r_oc <= r_c;
                r_oval <= sat_q16(acc[r_c[AW-1:0]]);
                r_last <= ({1'b0, r_c} == r_cols - 1'b1) &&
                          ({1'b0, r_r} == r_rows - 1'b1);
            end
        end
    end
    assign m_out.valid = r_ov;
    assign m_out.status = r_st;
    assign m_out.out_row = r_or;
    assign m_out.out_col = r_oc;
    assign m_out.out_value = r_oval;
    assign m_out.last = r_last;
endmodule
`default_nettype wire

// File: design/mm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One multiply-accumulate cell: registers the product, accumulates it,
// passes the B operand on to its neighbor each cycle.
module mm_cell
    import mm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [VAL_W-1:0]  i_a,
    input  wire logic [VAL_W-1:0]  i_b,
    output logic [VAL_W-1:0]       o_b,
    output logic signed [ACC_W-1:0] o_acc
);
    logic signed [63:0]      r_prod;
    logic                    r_pv;
    logic [VAL_W-1:0]        r_b;
    logic signed [ACC_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        r_b   <= i_b;
        r_pv  <= i_ctl.feed;
        r_prod <= signed'(i_a) * signed'(i_b);
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end
    assign o_b = r_b;
    assign o_acc = r_acc;
endmodule
`default_nettype wire

// File: design/mm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module mm_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid, i_in_ready,
    input wire logic i_out_valid, i_out_ready,
    input wire logic i_status, i_last,
    input wire logic [2:0] i_out_row, i_out_col,
    input wire logic [31:0] i_out_value
);
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> i_last && i_out_value == 32'd0) else $error("err beat");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> i_out_row == 3'd0 && i_out_col == 3'd0)
        else $error("err idx");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value))
        else $error("hold");
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !i_out_valid || i_out_ready) else $error("in stall");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid) else $error("reset");
endmodule

bind matrix_multiplier mm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(s_in.valid), .i_in_ready(s_in.ready),
    .i_out_valid(m_out.valid), .i_out_ready(m_out.ready),
    .i_status(m_out.status), .i_last(m_out.last),
    .i_out_row(m_out.out_row), .i_out_col(m_out.out_col),
    .i_out_value(m_out.out_value)
);
`default_nettype wire

// File: dv/matrix_multiplier_test.sv
`timescale 1ns / 1ps
module matrix_multiplier_test;
    import mm_pkg::*;

    typedef struct {
        logic [1:0]         action;
        logic [2:0]         row_index;
        logic [2:0]         col_index;
        logic signed [31:0] element_value;
    } t_cmd;

    typedef struct {
        logic               status;
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] out_value;
        logic               last;
    } t_elem;

    localparam int IDLE_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [DIM_W-1:0] i_cfg_data = '0;

    mm_in_if s_in ();
    mm_out_if m_out ();

    matrix_multiplier dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_in(s_in.sink), .m_out(m_out.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // golden copy of the stores and dimensions
    logic [31:0] a_mat [0:63];
    logic [31:0] b_mat [0:63];
    logic [63:0] a_seen, b_seen;
    int unsigned n_rows, n_inner, n_cols;

    t_cmd  cmd_q [$];
    t_elem c_elems_q [$];
    int    n_errors = 0;
    int    idle_cycles = 0;
    int    n_sent = 0;
    bit    hold_sender = 1'b0;
    bit    in_taken = 1'b0;

    task automatic report(input string what, input t_elem got, input t_elem exp_e);
        $display("mismatch %s: got st%0d r%0d c%0d v%h l%0d exp st%0d r%0d c%0d v%h l%0d",
                 what, got.status, got.out_row, got.out_col, got.out_value, got.last,
                 exp_e.status, exp_e.out_row, exp_e.out_col, exp_e.out_value, exp_e.last);
        n_errors++;
    endtask

    function automatic logic [31:0] c_element(input int r, input int c);
        logic signed [79:0] acc;
        logic signed [79:0] t;
        acc = '0;
        for (int k = 0; k < n_inner; k++)
            acc += 80'(signed'(a_mat[r*8+k])) * 80'(signed'(b_mat[k*8+c]));
        t = acc >>> 16;
        if (t > 80'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (t < -80'sh8000_0000) return 32'h8000_0000;
        return t[31:0];
    endfunction

    // expected results for one accepted beat
    task automatic predict_beat(input t_cmd cmd);
        t_elem e;
        int unsigned rl, cl;
        e = '{0, 0, 0, 0, 1};
        if (cmd.action == ACT_WRITE_A || cmd.action == ACT_WRITE_B) begin
            rl = (cmd.action == ACT_WRITE_A) ? n_rows : n_inner;
            cl = (cmd.action == ACT_WRITE_A) ? n_inner : n_cols;
            if (cmd.row_index >= rl || cmd.col_index >= cl) begin
                e.status = 1'b1;
            end else if (cmd.action == ACT_WRITE_A) begin
                a_mat[cmd.row_index*8+cmd.col_index] = cmd.element_value;
            end else begin
                b_mat[cmd.row_index*8+cmd.col_index] = cmd.element_value;
            end
            c_elems_q.push_back(e);
        end else if (cmd.action == ACT_MULTIPLY) begin
            for (int r = 0; r < n_rows; r++)
                for (int c = 0; c < n_cols; c++) begin
                    e.out_row = r;
                    e.out_col = c;
                    e.out_value = c_element(r, c);
                    e.last = (r == n_rows - 1) && (c == n_cols - 1);
                    c_elems_q.push_back(e);
                end
        end
    endtask

    // input beat taken at the rising edge
    always @(posedge i_clk) begin
        in_taken <= s_in.valid && s_in.ready;
    end

    // driver: bursts and gaps; a beat stays on the bus until taken
    int burst_left = 0, gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n && in_taken) begin
            void'(cmd_q.pop_front());
            n_sent <= n_sent + 1;
        end
        if (gap_left > 0) gap_left <= gap_left - 1;
        if (i_rst_n && s_in.valid && !in_taken) begin
            // beat still waiting: hold it
        end else if (!i_rst_n || hold_sender || cmd_q.size() == 0 || gap_left > 0) begin
            s_in.valid <= 1'b0;
        end else begin
            s_in.valid <= 1'b1;
            s_in.action <= cmd_q[0].action;
            s_in.row_index <= cmd_q[0].row_index;
            s_in.col_index <= cmd_q[0].col_index;
            s_in.element_value <= cmd_q[0].element_value;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 12);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // receiver stall pattern: alternating phases
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 96;
        if (stall_phase < 32) m_out.ready <= 1'b1;
        else if (stall_phase < 64) m_out.ready <= ($urandom_range(0, 3) != 0);
        else m_out.ready <= ($urandom_range(0, 2) == 0);
    end

    // monitor: predict on input beats, check output beats
    always @(posedge i_clk) begin
        t_elem got, exp_e;
        if (i_rst_n) begin
            if ((s_in.valid && s_in.ready) || (m_out.valid && m_out.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_in.valid && s_in.ready) begin
                predict_beat('{s_in.action, s_in.row_index, s_in.col_index,
                               s_in.element_value});
            end
            if (m_out.valid && m_out.ready) begin
                got = '{m_out.status, m_out.out_row, m_out.out_col, m_out.out_value,
                        m_out.last};
                if (c_elems_q.size() == 0) begin
                    report("unexpected beat", got, got);
                end else begin
                    exp_e = c_elems_q.pop_front();
                    if (got.status !== exp_e.status) report("status", got, exp_e);
                    else if (got.out_row !== exp_e.out_row) report("out_row", got, exp_e);
                    else if (got.out_col !== exp_e.out_col) report("out_col", got, exp_e);
                    else if (got.out_value !== exp_e.out_value)
                        report("out_value", got, exp_e);
                    else if (got.last !== exp_e.last) report("last", got, exp_e);
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL matrix_multiplier");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cmd mk(input logic [1:0] a, input int r, input int c,
                                input logic [31:0] v);
        t_cmd t;
        t.action = a;
        t.row_index = r;
        t.col_index = c;
        t.element_value = v;
        return t;
    endfunction

    task automatic wait_drained();
        while (cmd_q.size() != 0 || c_elems_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // set dimensions while idle; model saturation mirrored
    task automatic set_dims(input int unsigned ra, input int unsigned ki,
                            input int unsigned cb);
        int unsigned v [3];
        v = '{ra, ki, cb};
        for (int i = 0; i < 3; i++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_index <= i;
            i_cfg_data <= v[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_rows = (ra == 0) ? 1 : (ra > 8) ? 8 : ra;
        n_inner = (ki == 0) ? 1 : (ki > 8) ? 8 : ki;
        n_cols = (cb == 0) ? 1 : (cb > 8) ? 8 : cb;
    endtask

    // fill every valid entry (keeps multiplies off unwritten entries)
    task automatic load_all(input bit extreme);
        for (int r = 0; r < n_rows; r++)
            for (int k = 0; k < n_inner; k++) begin
                cmd_q.push_back(mk(ACT_WRITE_A, r, k,
                                   extreme ? 32'h7FFF_FFFF : rand_value()));
                a_seen[r*8+k] = 1'b1;
            end
        for (int k = 0; k < n_inner; k++)
            for (int c = 0; c < n_cols; c++) begin
                cmd_q.push_back(mk(ACT_WRITE_B, k, c,
                                   extreme ? 32'h8000_0000 : rand_value()));
                b_seen[k*8+c] = 1'b1;
            end
    endtask

    function automatic bit covered();
        for (int r = 0; r < n_rows; r++)
            for (int k = 0; k < n_inner; k++)
                if (!a_seen[r*8+k]) return 1'b0;
        for (int k = 0; k < n_inner; k++)
            for (int c = 0; c < n_cols; c++)
                if (!b_seen[k*8+c]) return 1'b0;
        return 1'b1;
    endfunction

    initial begin
        int phase;
        int unsigned r, c;
        t_cmd t;
        s_in.valid = 1'b0;
        s_in.action = '0;
        s_in.row_index = '0;
        s_in.col_index = '0;
        s_in.element_value = '0;
        m_out.ready = 1'b0;
        a_seen = '0;
        b_seen = '0;
        n_rows = 1;
        n_inner = 1;
        n_cols = 1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: 1x1x1 with extremes, ignored action, out-of-range writes
        cmd_q.push_back(mk(ACT_WRITE_A, 0, 0, 32'h7FFF_FFFF));
        cmd_q.push_back(mk(ACT_WRITE_B, 0, 0, 32'h7FFF_FFFF));
        a_seen[0] = 1'b1;
        b_seen[0] = 1'b1;
        cmd_q.push_back(mk(ACT_MULTIPLY, 7, 7, 32'hFFFF_FFFF));
        // sender holds off until everything has come back
        while (cmd_q.size() != 0) @(posedge i_clk);
        hold_sender = 1'b1;
        while (c_elems_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        hold_sender = 1'b0;
        cmd_q.push_back(mk(ACT_NONE, 5, 2, 32'h1234_5678));
        cmd_q.push_back(mk(ACT_WRITE_A, 0, 1, 32'h1));
        cmd_q.push_back(mk(ACT_WRITE_B, 7, 7, 32'h1));
        cmd_q.push_back(mk(ACT_WRITE_B, 0, 0, 32'h8000_0000));
        cmd_q.push_back(mk(ACT_MULTIPLY, 0, 0, 0));
        wait_drained();

        // register saturation: 0 -> 1, 15 -> 8
        set_dims(0, 15, 2);
        load_all(1'b1);
        cmd_q.push_back(mk(ACT_MULTIPLY, 0, 0, 0));
        wait_drained();

        // random phases across dimension settings, widest result included
        phase = 0;
        while (n_sent < 120) begin
            if (phase == 0) set_dims(8, 2, 8);
            else set_dims($urandom_range(1, 4), $urandom_range(1, 4),
                          $urandom_range(1, 4));
            phase++;
            if (!covered() || $urandom_range(0, 1)) begin
                load_all(1'b0);
            end
            for (int i = 0; i < 12; i++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        r = $urandom_range(0, n_rows - 1);
                        c = $urandom_range(0, n_inner - 1);
                        t = mk(ACT_WRITE_A, r, c, rand_value());
                        a_seen[r*8+c] = 1'b1;
                    end
                    4, 5, 6: begin
                        r = $urandom_range(0, n_inner - 1);
                        c = $urandom_range(0, n_cols - 1);
                        t = mk(ACT_WRITE_B, r, c, rand_value());
                        b_seen[r*8+c] = 1'b1;
                    end
                    7: t = mk($urandom_range(0, 1), $urandom_range(0, 7),
                              $urandom_range(0, 7), $urandom);
                    default: t = mk(($urandom_range(0, 4) == 0) ? ACT_NONE
                                    : ACT_MULTIPLY, $urandom_range(0, 7),
                                    $urandom_range(0, 7), $urandom);
                endcase
                cmd_q.push_back(t);
            end
            cmd_q.push_back(mk(ACT_MULTIPLY, 0, 0, 0));
            wait_drained();
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (n_errors == 0 && c_elems_q.size() == 0) begin
            $display("PASS matrix_multiplier");
        end else begin
            $display("FAIL matrix_multiplier");
        end
        $finish;
    end
endmodule
